// File: rtl/core/sorted_set_table_unit_defines.svh
// Assertion macros shared by the sorted set table RTL.
`ifndef SORTED_SET_TABLE_UNIT_DEFINES_SVH
`define SORTED_SET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SST_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/sst_pkg.sv
// Command, status and boundary constants for the sorted set table.
package sst_pkg;

    localparam logic [2:0] CMD_ADD        = 3'd0;
    localparam logic [2:0] CMD_REMOVE     = 3'd1;
    localparam logic [2:0] CMD_CONTAINS   = 3'd2;
    localparam logic [2:0] CMD_REMOVE_MIN = 3'd3;
    localparam logic [2:0] CMD_REMOVE_MAX = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

endpackage

// File: rtl/core/sst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/sorted_set_table_unit.sv
// Sorted set table: binary search plus element shifting over one RAM port pair.
// Flow: add, remove and contains first search with S probes (at most clog2(CAPACITY+1)), then S_EXEC;
// an insert or delete that moves M elements loops over read/write states, then S_RMIN, S_RMAX, S_DONE.
// Throughput: one command at a time; start is taken again in the cycle o_done is high.
// Reset clears the element count and control state; the RAM is not swept or cleared.
// Results appear for one cycle on o_done; the receiver cannot stall.
`include "sorted_set_table_unit_defines.svh"

module sorted_set_table_unit
    import sst_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic               o_found,
    output logic [1:0]         o_status,
    output logic [6:0]         o_count,
    output logic signed [31:0] o_min_value,
    output logic signed [31:0] o_max_value
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CWX = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_RMIN,
        S_RMAX,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_cmd;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_idx;
    logic               r_found;
    logic [1:0]         r_status;
    logic signed [31:0] r_min;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] elem;
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic [CW:0]        idx_next;
    logic [CWX-1:0]     count_ext;

    assign busy      = (r_state != S_IDLE);
    assign elem      = $signed(ram_rdata);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[CW:1];
    assign idx_next  = {1'b0, r_idx} + (CW+1)'(1);
    assign count_ext = CWX'(r_count);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = mid[AW-1:0];
        unique case (r_state)
            S_INS_RD: begin
                ram_raddr = AW'(r_idx - CW'(1));
                if (r_idx <= r_lo) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                    ram_wdata = r_value;
                end
            end
            S_INS_WR: begin
                ram_we = 1'b1;
            end
            S_DEL_RD: begin
                ram_raddr = AW'(idx_next);
            end
            S_DEL_WR: begin
                ram_we = 1'b1;
            end
            S_RMIN: begin
                ram_raddr = '0;
            end
            S_RMAX: begin
                ram_raddr = AW'(r_count - CW'(1));
            end
            default: begin
            end
        endcase
    end

    sst_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_status <= ST_OK;
            o_done   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_command;
                        r_value  <= i_value;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        if (i_command == CMD_ADD || i_command == CMD_REMOVE ||
                            i_command == CMD_CONTAINS) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_CMP: begin
                    if (elem <= r_value) begin
                        r_lo    <= CW'(mid + CW'(1));
                        r_found <= (elem == r_value);
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_SRCH;
                end
                S_EXEC: begin
                    r_state <= S_RMIN;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (!r_found) begin
                                if (r_count >= CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_idx   <= r_count;
                                    r_state <= S_INS_RD;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_found) begin
                                r_idx   <= CW'(r_lo - CW'(1));
                                r_state <= S_DEL_RD;
                            end
                        end
                        CMD_REMOVE_MIN: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_DEL_RD;
                            end
                        end
                        CMD_REMOVE_MAX: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_count <= CW'(r_count - CW'(1));
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_INS_RD: begin
                    if (r_idx > r_lo) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count <= CW'(r_count + CW'(1));
                        r_state <= S_RMIN;
                    end
                end
                S_INS_WR: begin
                    r_idx   <= CW'(r_idx - CW'(1));
                    r_state <= S_INS_RD;
                end
                S_DEL_RD: begin
                    if (idx_next < {1'b0, r_count}) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_count <= CW'(r_count - CW'(1));
                        r_state <= S_RMIN;
                    end
                end
                S_DEL_WR: begin
                    r_idx   <= CW'(idx_next);
                    r_state <= S_DEL_RD;
                end
                S_RMIN: begin
                    r_state <= S_RMAX;
                end
                S_RMAX: begin
                    r_min   <= elem;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_done   <= 1'b1;
                    o_found  <= r_found;
                    o_status <= r_status;
                    o_count  <= count_ext[6:0];
                    if (r_count == '0) begin
                        o_min_value <= INT_MAX;
                        o_max_value <= INT_MIN;
                    end else begin
                        o_min_value <= r_min;
                        o_max_value <= elem;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SST_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `SST_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `SST_ASSERT_NOW(a_we_busy, i_clk, i_rst_n, ram_we, busy)
    `SST_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, busy, r_count <= CW'(CAPACITY))
    `SST_ASSERT_NOW(a_full_status, i_clk, i_rst_n, o_done && (o_status == ST_FULL),
        r_count == CW'(CAPACITY))

endmodule
